### design/rtbm_pkg.sv
// Shared types and constants for the RGBA to BGR bitmap with mask unit.
package rtbm_pkg;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned DIM_RESET  = 1;

    // Alpha above this value counts as opaque (mask bit 0)
    localparam logic [7:0] ALPHA_OPAQUE_LIMIT = 8'h7F;

    // A partial mask byte is padded to this many bits
    localparam logic [3:0] MASK_BITS_PER_BYTE = 4'd8;

    // Output slot positions within one pixel's run of words
    localparam logic [2:0] SLOT_BLUE  = 3'd0;
    localparam logic [2:0] SLOT_GREEN = 3'd1;
    localparam logic [2:0] SLOT_RED   = 3'd2;
    localparam logic [2:0] SLOT_MASK  = 3'd3;

    // Colour bytes always sent per pixel, minus one (index of the red slot)
    localparam logic [2:0] COLOUR_LAST_SLOT = 3'd2;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam int unsigned QUEUE_CNT_W = 3;

    // One classified pixel, ready to be serialized
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] mask_byte;    // first mask byte; a second one is always zero
        logic [1:0] mask_count;   // mask bytes for this pixel, 0 to 2
        logic [2:0] last_slot;    // index of the final word of this pixel
        logic       row_done;
        logic       frame_done;
    } job_t;

endpackage

### design/rtbm_front.sv
// Front end: config registers, row/column tracking and mask packing per pixel.
module rtbm_front #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [rtbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          red,
    input  logic [7:0]                          green,
    input  logic [7:0]                          blue,
    input  logic [7:0]                          alpha,
    input  logic                                queue_full,
    output logic                                push,
    output rtbm_pkg::job_t                      push_job
);

    localparam int unsigned WCW  = $clog2(MAX_WIDTH);
    localparam int unsigned WDW0 = $clog2(MAX_WIDTH + 1);
    localparam int unsigned WDW  = (WDW0 > rtbm_pkg::CFG_DATA_W) ? WDW0 : rtbm_pkg::CFG_DATA_W;
    localparam int unsigned HCW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned HDW0 = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned HDW  = (HDW0 > rtbm_pkg::CFG_DATA_W) ? HDW0 : rtbm_pkg::CFG_DATA_W;

    logic [rtbm_pkg::CFG_DATA_W-1:0] width_reg,  width_next;
    logic [rtbm_pkg::CFG_DATA_W-1:0] height_reg, height_next;
    logic [WCW-1:0]                  col_reg,    col_next;
    logic [HCW-1:0]                  row_reg,    row_next;
    logic [7:0]                      acc_reg,    acc_next;
    logic [3:0]                      pos_reg,    pos_next;

    logic [WDW-1:0] width_eff;
    logic [HDW-1:0] height_eff;
    logic [WDW-1:0] col_inc;
    logic [HDW-1:0] row_inc;
    logic           row_end;
    logic           frame_end;
    logic           mask_bit;
    logic [7:0]     acc_shift;
    logic [3:0]     pos_inc;
    logic           byte_full;
    logic [7:0]     acc_left;
    logic [3:0]     pad_shift;
    logic [7:0]     pad_byte;
    logic [1:0]     mask_count;
    logic [1:0]     colour_pad;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign push      = in_valid && !queue_full;

    // Clamp the programmed dimensions into 1..MAX
    always_comb
    begin
        if (width_reg == '0)
            width_eff = WDW'(1);
        else if (WDW'(width_reg) > WDW'(MAX_WIDTH))
            width_eff = WDW'(MAX_WIDTH);
        else
            width_eff = WDW'(width_reg);

        if (height_reg == '0)
            height_eff = HDW'(1);
        else if (HDW'(height_reg) > HDW'(MAX_HEIGHT))
            height_eff = HDW'(MAX_HEIGHT);
        else
            height_eff = HDW'(height_reg);
    end

    assign col_inc   = WDW'(col_reg) + WDW'(1);
    assign row_inc   = HDW'(row_reg) + HDW'(1);
    assign row_end   = col_inc >= width_eff;
    assign frame_end = row_end && (row_inc >= height_eff);

    // Mask packing: shift in one bit, then pad to a 16-bit word at row end
    assign mask_bit  = (alpha <= rtbm_pkg::ALPHA_OPAQUE_LIMIT);
    assign acc_shift = {acc_reg[6:0], mask_bit};
    assign pos_inc   = pos_reg + 4'd1;
    assign byte_full = (pos_inc[2:0] == 3'd0);
    assign acc_left  = byte_full ? 8'd0 : acc_shift;
    assign pad_shift = rtbm_pkg::MASK_BITS_PER_BYTE - {1'b0, pos_inc[2:0]};
    assign pad_byte  = acc_left << pad_shift;

    always_comb
    begin
        if (!row_end)
            mask_count = byte_full ? 2'd1 : 2'd0;
        else if (pos_inc == 4'd0)
            mask_count = 2'd1;
        else if (byte_full || !pos_inc[3])
            mask_count = 2'd2;
        else
            mask_count = 2'd1;
    end

    assign colour_pad = row_end ? width_eff[1:0] : 2'd0;

    always_comb
    begin
        push_job.blue       = blue;
        push_job.green      = green;
        push_job.red        = red;
        push_job.mask_byte  = byte_full ? acc_shift : pad_byte;
        push_job.mask_count = mask_count;
        push_job.last_slot  = rtbm_pkg::COLOUR_LAST_SLOT + {1'b0, mask_count}
                              + {1'b0, colour_pad};
        push_job.row_done   = row_end;
        push_job.frame_done = frame_end;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rtbm_pkg::CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                rtbm_pkg::CFG_IMAGE_HEIGHT: height_next = cfg_data;
                default:                    width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (push)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_inc[HCW-1:0];
                acc_next = 8'd0;
                pos_next = 4'd0;
            end
            else
            begin
                col_next = col_inc[WCW-1:0];
                acc_next = acc_left;
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rtbm_pkg::CFG_DATA_W'(rtbm_pkg::DIM_RESET);
            height_reg <= rtbm_pkg::CFG_DATA_W'(rtbm_pkg::DIM_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
            acc_reg    <= 8'd0;
            pos_reg    <= 4'd0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

### design/rtbm_queue.sv
// Small job queue between the front end and the byte serializer.
module rtbm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rtbm_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rtbm_pkg::job_t head_job
);

    rtbm_pkg::job_t                       entries [rtbm_pkg::QUEUE_DEPTH];
    logic [rtbm_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rtbm_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rtbm_pkg::QUEUE_CNT_W-1:0]     count_reg,  count_next;

    assign full       = (count_reg == rtbm_pkg::QUEUE_CNT_W'(rtbm_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Hold payload in plain registers; no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/rtbm_back.sv
// Back end: serializes one job into colour, mask and padding words.
module rtbm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  rtbm_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           stream_select,
    output logic           last_in_run,
    output logic           row_done,
    output logic           frame_done
);

    logic [2:0] slot_reg, slot_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       stream_reg;
    logic       last_reg;
    logic       row_reg;
    logic       frame_reg;

    logic       load;
    logic       slot_last;
    logic       slot_mask;
    logic [7:0] slot_byte;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign slot_last = (slot_reg == head_job.last_slot);
    assign pop       = load && slot_last;
    assign slot_mask = (slot_reg >= rtbm_pkg::SLOT_MASK)
                       && (slot_reg < rtbm_pkg::SLOT_MASK + {1'b0, head_job.mask_count});

    always_comb
    begin
        case (slot_reg)
            rtbm_pkg::SLOT_BLUE:  slot_byte = head_job.blue;
            rtbm_pkg::SLOT_GREEN: slot_byte = head_job.green;
            rtbm_pkg::SLOT_RED:   slot_byte = head_job.red;
            rtbm_pkg::SLOT_MASK:  slot_byte = slot_mask ? head_job.mask_byte : 8'd0;
            default:              slot_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        if (load)
        begin
            slot_next  = slot_last ? rtbm_pkg::SLOT_BLUE : slot_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= rtbm_pkg::SLOT_BLUE;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= slot_byte;
            stream_reg <= slot_mask;
            last_reg   <= slot_last;
            row_reg    <= head_job.row_done;
            frame_reg  <= head_job.frame_done;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign stream_select = stream_reg;
    assign last_in_run   = last_reg;
    assign row_done      = row_reg;
    assign frame_done    = frame_reg;

endmodule

### design/rgba_to_bgr_bitmap_with_mask_unit.sv
// Top level: RGBA pixels in, BGR colour bytes and 1-bit mask bytes out.
// With the queue empty, a pixel's first word passes the job queue, then the output register.
// Throughput: one word per cycle while out_ready is high; a pixel is 3 to 8 words, 3 colour words plus
// mask bytes (0..2) and colour padding (0..3), all sent through the byte-wide output register.
// The front end runs ahead through a four-entry job queue. Reset: rst_n clears
// counters, mask state, queue and output valid; width and height return to 1.
module rgba_to_bgr_bitmap_with_mask_unit #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [rtbm_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    input  logic [7:0]                      alpha,
    // byte output
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            stream_select,
    output logic                            last_in_run,
    output logic                            row_done,
    output logic                            frame_done
);

    logic           push;
    rtbm_pkg::job_t push_job;
    logic           queue_full;
    logic           pop;
    logic           head_valid;
    rtbm_pkg::job_t head_job;

    // Front: classify each pixel, track row/frame position, pack mask bits
    rtbm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Queue: decouple the pixel rate from the byte rate
    rtbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back: walk the slots of the head job, one word per cycle unless the output stalls
    rtbm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .stream_select (stream_select),
        .last_in_run   (last_in_run),
        .row_done      (row_done),
        .frame_done    (frame_done)
    );

endmodule

### design/rtbm_checker.sv
// Port-level checker for the bitmap unit, bound to the top level.
module rtbm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       stream_select,
    input logic       last_in_run,
    input logic       row_done,
    input logic       frame_done
);

    // Drop output valid while in reset
    assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
        else $error("output valid after reset");

    // Hold a stalled word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(stream_select) && $stable(last_in_run))
        else $error("stalled output word changed");

    // Frame end always ends a row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> row_done)
        else $error("frame_done without row_done");

    // Row and frame flags stay constant over one pixel's words
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_in_run |=>
            !out_valid || ($stable(row_done) && $stable(frame_done)))
        else $error("row or frame flag changed within a pixel");

endmodule

bind rgba_to_bgr_bitmap_with_mask_unit rtbm_checker u_rtbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .stream_select (stream_select),
    .last_in_run   (last_in_run),
    .row_done      (row_done),
    .frame_done    (frame_done)
);
